// ===== rtl/core/riff_wave_chunk_parser_defines.svh =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser assertion macros
// shared property wrappers for the parser checks
// ----------------------------------------------------------------------------
`ifndef RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RWCP_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rwcp check failed");

// next-cycle implication, clocked on clk, off during reset
`define RWCP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rwcp check failed");

`endif

// ===== rtl/core/rwcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcp_pkg
// types, codes and constants of the riff/wave chunk parser
// ----------------------------------------------------------------------------
`default_nettype none

package rwcp_pkg;

	localparam int SIZE_BITS = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int MIN_FILE_BYTES = 44;
	localparam int FMT_MIN_LEN    = 16;
	localparam int RIFF_END       = 4;
	localparam int WAVE_START     = 8;
	localparam int WAVE_LAST      = 11;

	localparam logic [2:0]  HDR_LAST   = 3'd7;
	localparam logic [31:0] FMT_TAG    = 32'h20746D66;
	localparam logic [31:0] DATA_TAG   = 32'h61746164;
	localparam logic [15:0] FORMAT_PCM = 16'd1;

	localparam logic [15:0] RST_CHANNELS = 16'd2;
	localparam logic [31:0] RST_RATE     = 32'd48000;
	localparam logic [15:0] RST_BITS     = 16'd24;
	localparam logic [15:0] RST_ALIGN    = 16'd6;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_PAY,
		PH_PAD,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		TAG_OTHER,
		TAG_FMT,
		TAG_DATA
	} tag_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_MAGIC,
		ST_TRUNC,
		ST_FMT_SHORT,
		ST_MISSING,
		ST_FORMAT,
		ST_FRAMES
	} status_t;

	typedef enum logic [1:0] {
		REG_CHANNELS,
		REG_RATE,
		REG_BITS,
		REG_ALIGN
	} reg_index_t;

	typedef struct packed {
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [15:0] align;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pcm_byte;
		logic       pcm_valid;
		logic       chunk_start;
		logic       done_res;
		logic [2:0] status;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	function automatic logic [7:0] riff_magic(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0:    c = 8'h52;
			2'd1:    c = 8'h49;
			default: c = 8'h46;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] wave_magic(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0:    c = 8'h57;
			2'd1:    c = 8'h41;
			2'd2:    c = 8'h56;
			default: c = 8'h45;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rwcp_in_if.sv =====
// ----------------------------------------------------------------------------
// rwcp_in_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
`default_nettype none

interface rwcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source(output valid, output in_byte, output end_of_file, input ready);
	modport sink(input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rwcp_out_if.sv =====
// ----------------------------------------------------------------------------
// rwcp_out_if
// result channel out of the parser
// ----------------------------------------------------------------------------
`default_nettype none

interface rwcp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pcm_byte;
	logic       pcm_valid;
	logic       chunk_start;
	logic       done_res;
	logic [2:0] status;
	logic       last;

	modport source(output valid, output pcm_byte, output pcm_valid, output chunk_start,
		output done_res, output status, output last, input ready);
	modport sink(input valid, input pcm_byte, input pcm_valid, input chunk_start,
		input done_res, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/riff_wave_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser
// the input stage registers each accepted byte, then its results are written
// into the result queue; throughput: one file byte per cycle while the result
// queue has room; a data byte that also ends the file gives two results, one
// output transfer per cycle, and the input is held while the result queue drains
// reset: arst_n clears the walk and the result queue and loads the default
// required values
// ----------------------------------------------------------------------------
`default_nettype none

module riff_wave_chunk_parser (
	input  logic        clk,
	input  logic        arst_n,
	rwcp_in_if.sink     feed,
	rwcp_out_if.source  result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	rwcp_pkg::cfg_t                   cfg;
	rwcp_pkg::in_item_t               item_s1;
	logic                             valid_s1;
	rwcp_pkg::push_t                  push;
	logic [rwcp_pkg::FIFO_CW-1:0]     fill;
	logic                             take;

	assign take       = feed.valid && feed.ready;
	assign feed.ready = (4'(fill) + 4'(push.cnt)) <= 4'(rwcp_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.in_byte     <= feed.in_byte;
			item_s1.end_of_file <= feed.end_of_file;
		end
	end

	rwcp_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rwcp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.cfg      (cfg),
		.push     (push)
	);

	rwcp_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.fill   (fill),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rwcp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rwcp_cfg_regs
// required fmt values, written through the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module rwcp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [31:0]   wr_data,
	output rwcp_pkg::cfg_t cfg
);

	rwcp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels <= rwcp_pkg::RST_CHANNELS;
			cfg_q.rate     <= rwcp_pkg::RST_RATE;
			cfg_q.bits     <= rwcp_pkg::RST_BITS;
			cfg_q.align    <= rwcp_pkg::RST_ALIGN;
		end else if (wr_en) begin
			unique case (rwcp_pkg::reg_index_t'(wr_index))
				rwcp_pkg::REG_CHANNELS: cfg_q.channels <= wr_data[15:0];
				rwcp_pkg::REG_RATE:     cfg_q.rate     <= wr_data;
				rwcp_pkg::REG_BITS:     cfg_q.bits     <= wr_data[15:0];
				rwcp_pkg::REG_ALIGN:    cfg_q.align    <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/rwcp_parse.sv =====
// ----------------------------------------------------------------------------
// rwcp_parse
// chunk walker: magic checks, header decode, fmt capture, data pass and status
// ----------------------------------------------------------------------------
`default_nettype none

module rwcp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  rwcp_pkg::in_item_t item_s1,
	input  rwcp_pkg::cfg_t     cfg,
	output rwcp_pkg::push_t    push
);

	localparam int SB = rwcp_pkg::SIZE_BITS;

	rwcp_pkg::phase_t phase_q, phase_d;
	rwcp_pkg::tag_t   tag_q, tag_d;
	logic [SB-1:0]    byte_cnt_q, byte_cnt_d;
	logic [SB-1:0]    rem_q, rem_d;
	logic [31:0]      shift_q, shift_d;
	logic [31:0]      len_q, len_d;
	logic [15:0]      fmt_q, fmt_d;
	logic [15:0]      chan_q, chan_d;
	logic [31:0]      rate_q, rate_d;
	logic [15:0]      align_q, align_d;
	logic [15:0]      bits_q, bits_d;
	logic [1:0]       found_q, found_d;
	logic [15:0]      rest_q, rest_d;
	logic             empty_q, empty_d;
	logic [2:0]       err_q, err_d;

	logic [7:0]  b;
	logic [2:0]  hdr_idx;
	logic [31:0] off;
	logic [16:0] rest_inc;
	logic        do_finish;
	logic        emit;
	logic        start;
	logic [2:0]  status;
	rwcp_pkg::out_item_t data_item;
	rwcp_pkg::out_item_t stat_item;

	always_comb begin
		phase_d    = phase_q;
		tag_d      = tag_q;
		byte_cnt_d = byte_cnt_q;
		rem_d      = rem_q;
		shift_d    = shift_q;
		len_d      = len_q;
		fmt_d      = fmt_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		align_d    = align_q;
		bits_d     = bits_q;
		found_d    = found_q;
		rest_d     = rest_q;
		empty_d    = empty_q;
		err_d      = err_q;
		b          = item_s1.in_byte;
		hdr_idx    = rem_q[2:0];
		off        = len_q - 32'(rem_q);
		rest_inc   = {1'b0, rest_q} + 17'd1;
		do_finish  = 1'b0;
		emit       = 1'b0;
		start      = empty_q;
		status     = rwcp_pkg::ST_OK;

		if (valid_s1) begin
			if (byte_cnt_q != '1) begin
				byte_cnt_d = byte_cnt_q + 1'b1;
			end
			unique case (phase_q)
				rwcp_pkg::PH_RIFF: begin
					if (byte_cnt_q < SB'(rwcp_pkg::RIFF_END) &&
						b != rwcp_pkg::riff_magic(byte_cnt_q[1:0])) begin
						err_d   = rwcp_pkg::ST_MAGIC;
						phase_d = rwcp_pkg::PH_STOP;
					end else if (byte_cnt_q >= SB'(rwcp_pkg::WAVE_START) &&
						byte_cnt_q <= SB'(rwcp_pkg::WAVE_LAST) &&
						b != rwcp_pkg::wave_magic(byte_cnt_q[1:0])) begin
						err_d   = rwcp_pkg::ST_MAGIC;
						phase_d = rwcp_pkg::PH_STOP;
					end else if (byte_cnt_q >= SB'(rwcp_pkg::WAVE_LAST)) begin
						phase_d = rwcp_pkg::PH_HDR;
						rem_d   = '0;
					end
				end
				rwcp_pkg::PH_HDR: begin
					if (!hdr_idx[2]) begin
						shift_d = {b, shift_q[31:8]};
					end else begin
						len_d[8*hdr_idx[1:0] +: 8] = b;
					end
					if (hdr_idx != rwcp_pkg::HDR_LAST) begin
						rem_d = SB'(hdr_idx) + 1'b1;
					end else begin
						if (shift_q == rwcp_pkg::FMT_TAG) begin
							tag_d = rwcp_pkg::TAG_FMT;
						end else if (shift_q == rwcp_pkg::DATA_TAG) begin
							tag_d = rwcp_pkg::TAG_DATA;
						end else begin
							tag_d = rwcp_pkg::TAG_OTHER;
						end
						if ((33'(len_d) >> SB) != 33'd0) begin
							err_d   = rwcp_pkg::ST_TRUNC;
							phase_d = rwcp_pkg::PH_STOP;
						end else begin
							rem_d = len_d[SB-1:0];
							if (tag_d == rwcp_pkg::TAG_DATA) begin
								rest_d  = '0;
								empty_d = 1'b1;
							end
							if (len_d == 32'd0) begin
								do_finish = 1'b1;
							end else begin
								phase_d = rwcp_pkg::PH_PAY;
							end
						end
					end
				end
				rwcp_pkg::PH_PAY: begin
					if (rem_q == '0) begin
						do_finish = 1'b1;
					end else begin
						if (tag_q == rwcp_pkg::TAG_FMT && off[31:4] == 28'd0) begin
							case (off[3:0])
								4'd0:  fmt_d[7:0]    = b;
								4'd1:  fmt_d[15:8]   = b;
								4'd2:  chan_d[7:0]   = b;
								4'd3:  chan_d[15:8]  = b;
								4'd4:  rate_d[7:0]   = b;
								4'd5:  rate_d[15:8]  = b;
								4'd6:  rate_d[23:16] = b;
								4'd7:  rate_d[31:24] = b;
								4'd12: align_d[7:0]  = b;
								4'd13: align_d[15:8] = b;
								4'd14: bits_d[7:0]   = b;
								4'd15: bits_d[15:8]  = b;
								default: ;
							endcase
						end else if (tag_q == rwcp_pkg::TAG_DATA) begin
							emit    = 1'b1;
							empty_d = 1'b0;
							if (cfg.align != 16'd0 && rest_inc >= {1'b0, cfg.align}) begin
								rest_d = '0;
							end else begin
								rest_d = rest_inc[15:0];
							end
						end
						rem_d = rem_q - 1'b1;
						if (rem_q == SB'(1)) begin
							do_finish = 1'b1;
						end
					end
				end
				rwcp_pkg::PH_PAD: begin
					phase_d = rwcp_pkg::PH_HDR;
					rem_d   = '0;
				end
				default: ;
			endcase

			if (do_finish) begin
				if (tag_d == rwcp_pkg::TAG_FMT && len_d < 32'(rwcp_pkg::FMT_MIN_LEN)) begin
					err_d   = rwcp_pkg::ST_FMT_SHORT;
					phase_d = rwcp_pkg::PH_STOP;
				end else begin
					if (tag_d == rwcp_pkg::TAG_FMT) begin
						found_d[0] = 1'b1;
					end
					if (tag_d == rwcp_pkg::TAG_DATA) begin
						found_d[1] = 1'b1;
					end
					phase_d = len_d[0] ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_HDR;
					rem_d   = '0;
				end
			end

			// end of file status, then back to the start of a file
			if (byte_cnt_d < SB'(rwcp_pkg::MIN_FILE_BYTES)) begin
				status = rwcp_pkg::ST_MAGIC;
			end else if (err_d != 3'd0) begin
				status = err_d;
			end else if (phase_d == rwcp_pkg::PH_PAY && rem_d != '0) begin
				status = rwcp_pkg::ST_TRUNC;
			end else if (found_d != 2'b11) begin
				status = rwcp_pkg::ST_MISSING;
			end else if (fmt_d != rwcp_pkg::FORMAT_PCM || chan_d != cfg.channels ||
				rate_d != cfg.rate || bits_d != cfg.bits || align_d != cfg.align) begin
				status = rwcp_pkg::ST_FORMAT;
			end else if (empty_d || rest_d != 16'd0) begin
				status = rwcp_pkg::ST_FRAMES;
			end

			if (item_s1.end_of_file) begin
				phase_d    = rwcp_pkg::PH_RIFF;
				tag_d      = rwcp_pkg::TAG_OTHER;
				byte_cnt_d = '0;
				rem_d      = '0;
				shift_d    = '0;
				len_d      = '0;
				fmt_d      = '0;
				chan_d     = '0;
				rate_d     = '0;
				align_d    = '0;
				bits_d     = '0;
				found_d    = '0;
				rest_d     = '0;
				empty_d    = 1'b1;
				err_d      = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rwcp_pkg::PH_RIFF;
			tag_q      <= rwcp_pkg::TAG_OTHER;
			byte_cnt_q <= '0;
			rem_q      <= '0;
			shift_q    <= '0;
			len_q      <= '0;
			fmt_q      <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			align_q    <= '0;
			bits_q     <= '0;
			found_q    <= '0;
			rest_q     <= '0;
			empty_q    <= 1'b1;
			err_q      <= '0;
		end else begin
			phase_q    <= phase_d;
			tag_q      <= tag_d;
			byte_cnt_q <= byte_cnt_d;
			rem_q      <= rem_d;
			shift_q    <= shift_d;
			len_q      <= len_d;
			fmt_q      <= fmt_d;
			chan_q     <= chan_d;
			rate_q     <= rate_d;
			align_q    <= align_d;
			bits_q     <= bits_d;
			found_q    <= found_d;
			rest_q     <= rest_d;
			empty_q    <= empty_d;
			err_q      <= err_d;
		end
	end

	always_comb begin
		data_item             = '0;
		data_item.pcm_byte    = b;
		data_item.pcm_valid   = 1'b1;
		data_item.chunk_start = start;
		data_item.last        = !item_s1.end_of_file;
		stat_item             = '0;
		stat_item.done_res    = 1'b1;
		stat_item.status      = status;
		stat_item.last        = 1'b1;

		push = '0;
		if (valid_s1) begin
			if (emit && item_s1.end_of_file) begin
				push.cnt    = 2'd2;
				push.first  = data_item;
				push.second = stat_item;
			end else if (emit) begin
				push.cnt   = 2'd1;
				push.first = data_item;
			end else if (item_s1.end_of_file) begin
				push.cnt   = 2'd1;
				push.first = stat_item;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rwcp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rwcp_result_fifo
// small result queue, takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module rwcp_result_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rwcp_pkg::push_t                 push,
	output logic [rwcp_pkg::FIFO_CW-1:0]    fill,
	rwcp_out_if.source                      result
);

	localparam int AW = rwcp_pkg::FIFO_AW;
	localparam int CW = rwcp_pkg::FIFO_CW;

	rwcp_pkg::out_item_t entry_q [rwcp_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	rwcp_pkg::out_item_t head;

	assign pop = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_ptr_q + AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + AW'(pop);
			cnt_q    <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

	assign head               = entry_q[rd_ptr_q];
	assign result.valid       = cnt_q != '0;
	assign result.pcm_byte    = head.pcm_byte;
	assign result.pcm_valid   = head.pcm_valid;
	assign result.chunk_start = head.chunk_start;
	assign result.done_res    = head.done_res;
	assign result.status      = head.status;
	assign result.last        = head.last;
	assign fill               = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/rwcp_checker.sv =====
// ----------------------------------------------------------------------------
// rwcp_checker
// port level checks on the parser result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "riff_wave_chunk_parser_defines.svh"

module rwcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pcm_byte,
	input logic       pcm_valid,
	input logic       chunk_start,
	input logic       done_res,
	input logic [2:0] status,
	input logic       last
);

	`RWCP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pcm_byte) && $stable(pcm_valid) && $stable(done_res) && $stable(status) && $stable(last))
	`RWCP_ASSERT_IMPL(a_status_alone, out_valid && done_res, last && !pcm_valid && !chunk_start)
	`RWCP_ASSERT_IMPL(a_start_on_data, out_valid && chunk_start, pcm_valid && !done_res)
	`RWCP_ASSERT_IMPL(a_status_code, out_valid && done_res, status <= rwcp_pkg::ST_FRAMES)
	`RWCP_ASSERT_NEXT(a_status_follows, out_valid && out_ready && pcm_valid && !last, out_valid && done_res)

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.pcm_byte    (result.pcm_byte),
	.pcm_valid   (result.pcm_valid),
	.chunk_start (result.chunk_start),
	.done_res    (result.done_res),
	.status      (result.status),
	.last        (result.last)
);

`default_nettype wire

// ===== bench/riff_wave_chunk_parser_tb.sv =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_tb
// feeds whole riff/wave files byte by byte through the parser, with tiny and
// broken files first and then random files built around the current required
// format; an in-bench parser predicts every pcm byte and status transfer,
// and the result channel is checked in order under random stalls
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rwcp_pkg::*;

	localparam logic [31:0] RIFF_TEXT = "RIFF";
	localparam logic [31:0] WAVE_TEXT = "WAVE";

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;

	rwcp_in_if  feed_if ();
	rwcp_out_if result_if ();

	riff_wave_chunk_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// required values as last written
	cfg_t wanted;

	// in-bench walk of the current file
	phase_t      walk_phase;
	logic [31:0] byte_total;
	logic [31:0] tag_window;
	tag_t        chunk_kind;
	logic [31:0] chunk_len;
	logic [31:0] chunk_left;
	logic        pad_due;
	logic [15:0] got_format;
	logic [15:0] got_channels;
	logic [31:0] got_rate;
	logic [15:0] got_align;
	logic [15:0] got_bits;
	logic        have_fmt;
	logic        have_data;
	logic [15:0] frame_rest;
	logic        data_none;
	status_t     walk_error;

	in_item_t    feed_queue[$];
	out_item_t   expected_results[$];
	logic [7:0]  file_image[$];
	logic        pad_last;

	int unsigned bytes_queued;
	int unsigned bytes_taken;
	int unsigned mismatches;
	int unsigned burst_left;
	int unsigned gap_left;
	logic [9:0]  stall_tick;
	in_item_t    next_item;
	out_item_t   seen_item;
	out_item_t   due_item;

	task automatic clear_walk();
		walk_phase = PH_RIFF;
		byte_total = '0;
		tag_window = '0;
		chunk_kind = TAG_OTHER;
		chunk_len = '0;
		chunk_left = '0;
		pad_due = 1'b0;
		got_format = '0;
		got_channels = '0;
		got_rate = '0;
		got_align = '0;
		got_bits = '0;
		have_fmt = 1'b0;
		have_data = 1'b0;
		frame_rest = '0;
		data_none = 1'b1;
		walk_error = ST_OK;
	endtask

	task automatic stop_walk(input status_t code);
		walk_error = code;
		walk_phase = PH_STOP;
	endtask

	task automatic close_chunk();
		if (chunk_kind == TAG_FMT && chunk_len < FMT_MIN_LEN) begin
			stop_walk(ST_FMT_SHORT);
		end else begin
			if (chunk_kind == TAG_FMT) have_fmt = 1'b1;
			if (chunk_kind == TAG_DATA) have_data = 1'b1;
			pad_due = chunk_len[0];
			walk_phase = pad_due ? PH_PAD : PH_HDR;
			chunk_left = '0;
		end
	endtask

	function automatic status_t file_verdict();
		if (byte_total < MIN_FILE_BYTES) return ST_MAGIC;
		if (walk_error != ST_OK) return walk_error;
		if (walk_phase == PH_PAY && chunk_left != 0) return ST_TRUNC;
		if (!(have_fmt && have_data)) return ST_MISSING;
		if (got_format != FORMAT_PCM || got_channels != wanted.channels ||
			got_rate != wanted.rate || got_bits != wanted.bits ||
			got_align != wanted.align) return ST_FORMAT;
		if (data_none || frame_rest != 0) return ST_FRAMES;
		return ST_OK;
	endfunction

	task automatic parse_step(input logic [7:0] b, input logic eof);
		logic [31:0] pos;
		logic [31:0] off;
		int          k;
		out_item_t   r;
		out_item_t   produced[$];
		pos = byte_total;
		if (byte_total != 32'hFFFF_FFFF) byte_total++;
		case (walk_phase)
			PH_RIFF: begin
				k = pos[1:0];
				if (pos < RIFF_END && b != RIFF_TEXT[31 - 8 * k -: 8])
					stop_walk(ST_MAGIC);
				else if (pos >= WAVE_START && pos <= WAVE_LAST && b != WAVE_TEXT[31 - 8 * k -: 8])
					stop_walk(ST_MAGIC);
				else if (pos >= WAVE_LAST) begin
					walk_phase = PH_HDR;
					chunk_left = '0;
				end
			end
			PH_HDR: begin
				k = chunk_left[2:0];
				if (k < 4) begin
					tag_window = {b, tag_window[31:8]};
					if (k == 0) chunk_len = '0;
				end else begin
					chunk_len[8 * (k - 4) +: 8] = b;
				end
				if (k != HDR_LAST) begin
					chunk_left = k + 1;
				end else begin
					chunk_kind = (tag_window == FMT_TAG) ? TAG_FMT :
						(tag_window == DATA_TAG) ? TAG_DATA : TAG_OTHER;
					chunk_left = chunk_len;
					if (chunk_kind == TAG_DATA) begin
						frame_rest = '0;
						data_none = 1'b1;
					end
					if (chunk_left == 0) close_chunk();
					else walk_phase = PH_PAY;
				end
			end
			PH_PAY: begin
				if (chunk_left == 0) begin
					close_chunk();
				end else begin
					off = chunk_len - chunk_left;
					if (chunk_kind == TAG_FMT) begin
						if (off < 2) got_format[8 * off[0] +: 8] = b;
						else if (off < 4) got_channels[8 * off[0] +: 8] = b;
						else if (off < 8) got_rate[8 * off[1:0] +: 8] = b;
						else if (off == 12 || off == 13) got_align[8 * off[0] +: 8] = b;
						else if (off == 14 || off == 15) got_bits[8 * off[0] +: 8] = b;
					end else if (chunk_kind == TAG_DATA) begin
						r = '{pcm_byte: b, pcm_valid: 1'b1, chunk_start: data_none,
							done_res: 1'b0, status: ST_OK, last: 1'b0};
						produced.push_back(r);
						data_none = 1'b0;
						if (wanted.align != 0 && {1'b0, frame_rest} + 17'd1 >= {1'b0, wanted.align})
							frame_rest = '0;
						else
							frame_rest = frame_rest + 16'd1;
					end
					chunk_left--;
					if (chunk_left == 0) close_chunk();
				end
			end
			PH_PAD: begin
				pad_due = 1'b0;
				walk_phase = PH_HDR;
				chunk_left = '0;
			end
			default: ;
		endcase
		if (eof) begin
			r = '{pcm_byte: 8'h00, pcm_valid: 1'b0, chunk_start: 1'b0,
				done_res: 1'b1, status: file_verdict(), last: 1'b0};
			produced.push_back(r);
			clear_walk();
		end
		if (produced.size() != 0) produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i]) expected_results.push_back(produced[i]);
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_if.valid <= 1'b0;
			feed_if.in_byte <= '0;
			feed_if.end_of_file <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (feed_if.valid && feed_if.ready) begin
				parse_step(feed_if.in_byte, feed_if.end_of_file);
				bytes_taken++;
			end
			if (!feed_if.valid || feed_if.ready) begin
				if (gap_left != 0 || feed_queue.size() == 0) begin
					feed_if.valid <= 1'b0;
					if (gap_left != 0) gap_left <= gap_left - 1;
				end else begin
					next_item = feed_queue.pop_front();
					feed_if.valid <= 1'b1;
					feed_if.in_byte <= next_item.in_byte;
					feed_if.end_of_file <= next_item.end_of_file;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 64);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// receiver: stall pattern is chosen by the top bits of a free-running tick counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_tick <= '0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				seen_item = '{pcm_byte: result_if.pcm_byte, pcm_valid: result_if.pcm_valid,
					chunk_start: result_if.chunk_start, done_res: result_if.done_res,
					status: result_if.status, last: result_if.last};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t unexpected transfer: byte %h pv %b cs %b done %b st %0d last %b",
							$realtime, seen_item.pcm_byte, seen_item.pcm_valid,
							seen_item.chunk_start, seen_item.done_res, seen_item.status,
							seen_item.last);
				end else begin
					due_item = expected_results.pop_front();
					if (seen_item !== due_item) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t mismatch: expected byte %h pv %b cs %b done %b st %0d last %b",
								$realtime, due_item.pcm_byte, due_item.pcm_valid,
								due_item.chunk_start, due_item.done_res, due_item.status,
								due_item.last);
							$display("%0t mismatch: got      byte %h pv %b cs %b done %b st %0d last %b",
								$realtime, seen_item.pcm_byte, seen_item.pcm_valid,
								seen_item.chunk_start, seen_item.done_res, seen_item.status,
								seen_item.last);
						end
					end
				end
			end
			stall_tick <= stall_tick + 10'd1;
			case (stall_tick[9:8])
				2'd0:    result_if.ready <= 1'b1;
				2'd1:    result_if.ready <= ($urandom_range(0, 1) == 1);
				2'd2:    result_if.ready <= (stall_tick[2:0] != 3'd0);
				default: result_if.ready <= (stall_tick[4:3] == 2'd0);
			endcase
		end
	end

	task automatic add_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) file_image.push_back(v[8 * i +: 8]);
	endtask

	task automatic add_text(input logic [31:0] w);
		for (int i = 0; i < 4; i++) file_image.push_back(w[31 - 8 * i -: 8]);
	endtask

	task automatic add_chunk(input tag_t kind, input bit big);
		logic [127:0] fmt_body;
		logic [31:0]  len;
		logic [31:0]  tag_word;
		int           p;
		case (kind)
			TAG_FMT: begin
				len = FMT_MIN_LEN;
				if (!big) begin
					case ($urandom_range(0, 9))
						0:       len = $urandom_range(0, FMT_MIN_LEN - 1);
						1:       len = $urandom_range(FMT_MIN_LEN + 1, FMT_MIN_LEN + 4);
						default: ;
					endcase
				end
				fmt_body = {wanted.bits, wanted.align, $urandom(), wanted.rate,
					wanted.channels, FORMAT_PCM};
				if (!big && $urandom_range(0, 5) == 0) begin
					// one bit off in format, channels, rate, align or bits
					p = $urandom_range(0, 95);
					if (p >= 64) p += 32;
					fmt_body[p] = ~fmt_body[p];
				end
				add_le(FMT_TAG, 4);
				add_le(len, 4);
				for (int i = 0; i < len; i++)
					file_image.push_back(i < 16 ? fmt_body[8 * i +: 8] : 8'($urandom));
			end
			TAG_DATA: begin
				if (big)
					len = wanted.align;
				else if (wanted.align > 64)
					len = $urandom_range(0, 9);
				else begin
					len = $urandom_range(0, 4) * wanted.align;
					if (wanted.align > 1 && $urandom_range(0, 5) == 0)
						len += $urandom_range(1, wanted.align - 1);
				end
				add_le(DATA_TAG, 4);
				add_le(len, 4);
				for (int i = 0; i < len; i++) file_image.push_back($urandom_range(0, 255));
			end
			default: begin
				tag_word = $urandom();
				if (tag_word == FMT_TAG || tag_word == DATA_TAG) tag_word[0] = ~tag_word[0];
				len = $urandom_range(0, 9);
				add_le(tag_word, 4);
				add_le(len, 4);
				for (int i = 0; i < len; i++) file_image.push_back($urandom_range(0, 255));
			end
		endcase
		if (len[0]) file_image.push_back($urandom_range(0, 255));
		pad_last = len[0];
	endtask

	task automatic build_file(input bit big);
		tag_t kinds[$];
		int   cut;
		int   k;
		file_image = {};
		pad_last = 1'b0;
		add_text(RIFF_TEXT);
		add_le($urandom(), 4);
		add_text(WAVE_TEXT);
		if (!big && $urandom_range(0, 15) == 0) begin
			k = $urandom_range(0, 7);
			if (k >= 4) k += 4;
			file_image[k] = file_image[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (big || $urandom_range(0, 9) != 0) kinds.push_back(TAG_FMT);
		if (big || $urandom_range(0, 9) != 0) kinds.push_back(TAG_DATA);
		if (!big) begin
			repeat ($urandom_range(0, 2)) kinds.insert($urandom_range(0, kinds.size()), TAG_OTHER);
			if ($urandom_range(0, 5) == 0)
				kinds.insert($urandom_range(0, kinds.size()),
					$urandom_range(0, 1) ? TAG_FMT : TAG_DATA);
		end
		foreach (kinds[i]) add_chunk(kinds[i], big);
		if (!big) begin
			case ($urandom_range(0, 11))
				0: begin
					cut = $urandom_range(1, file_image.size() - 1);
					while (file_image.size() > cut) void'(file_image.pop_back());
				end
				1: repeat ($urandom_range(1, 7)) file_image.push_back($urandom_range(0, 255));
				2: if (pad_last) void'(file_image.pop_back());
				default: ;
			endcase
		end
	endtask

	task automatic settle();
		while (bytes_taken != bytes_queued || expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_file(input int pause_at);
		in_item_t it;
		for (int i = 0; i < file_image.size(); i++) begin
			if (i == pause_at) settle();
			it.in_byte = file_image[i];
			it.end_of_file = (i == file_image.size() - 1);
			feed_queue.push_back(it);
			bytes_queued++;
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_CHANNELS: wanted.channels = val[15:0];
			REG_RATE:     wanted.rate = val;
			REG_BITS:     wanted.bits = val[15:0];
			default:      wanted.align = val[15:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input cfg_t c);
		settle();
		write_reg(REG_CHANNELS, 32'(c.channels));
		write_reg(REG_RATE, c.rate);
		write_reg(REG_BITS, 32'(c.bits));
		write_reg(REG_ALIGN, 32'(c.align));
	endtask

	task automatic run_phase(input int budget, input bit with_big);
		int phase_bytes;
		bit paused;
		phase_bytes = 0;
		paused = 1'b0;
		if (with_big) begin
			build_file(1'b1);
			send_file(-1);
		end
		while (phase_bytes < budget) begin
			build_file(1'b0);
			if (!paused) send_file($urandom_range(1, file_image.size() - 1));
			else send_file(-1);
			paused = 1'b1;
			phase_bytes += file_image.size();
		end
	endtask

	initial begin
		cfg_t mixed;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		feed_if.valid = 1'b0;
		feed_if.in_byte = '0;
		feed_if.end_of_file = 1'b0;
		result_if.ready = 1'b0;
		bytes_queued = 0;
		bytes_taken = 0;
		mismatches = 0;
		wanted = '{channels: RST_CHANNELS, rate: RST_RATE, bits: RST_BITS, align: RST_ALIGN};
		clear_walk();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte files, bad riff magic, bad wave magic
		file_image = '{8'h00};
		send_file(-1);
		file_image = '{8'hFF};
		send_file(-1);
		file_image = {};
		add_text("RIFX");
		send_file(-1);
		file_image = {};
		add_text(RIFF_TEXT);
		add_le(32'h55AA_00FF, 4);
		add_text("WAVF");
		send_file(-1);

		run_phase(300, 1'b1);
		apply_setting('{channels: 16'd1, rate: 32'd1, bits: 16'd1, align: 16'd1});
		run_phase(300, 1'b0);
		apply_setting('{channels: 16'hFFFF, rate: 32'hFFFF_FFFF, bits: 16'hFFFF, align: 16'hFFFF});
		run_phase(300, 1'b0);
		mixed.channels = 16'($urandom_range(1, 65535));
		mixed.rate = $urandom_range(32'hFFFF_FFFF, 1);
		mixed.bits = 16'($urandom_range(1, 65535));
		mixed.align = 16'($urandom_range(1, 8));
		apply_setting(mixed);
		run_phase(300, 1'b1);
		apply_setting('{channels: 16'd2, rate: 32'd44100, bits: 16'd16, align: 16'd4});
		run_phase(300, 1'b0);
		settle();

		if (mismatches == 0) begin
			$display("riff_wave_chunk_parser verification clean");
		end else begin
			$display("riff_wave_chunk_parser verification failed");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("riff_wave_chunk_parser verification failed");
		$finish;
	end

endmodule
